[rtl/core/csts_pkg.sv]
// ----------------------------------------------------------------------------
// csts_pkg
// Shared types and constants for the C source token splitter: scan modes,
// token kinds, result beat layout and character codes.
// ----------------------------------------------------------------------------
package csts_pkg;

    localparam int LimitWidth = 10;
    localparam logic [LimitWidth-1:0] LIMIT_RESET = 10'd100;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_BLOCK,
        MODE_LINE,
        MODE_DIR,
        MODE_STR,
        MODE_NUM,
        MODE_IDENT
    } mode_t;

    typedef enum logic [2:0] {
        KIND_IDENT,
        KIND_NUM,
        KIND_STR,
        KIND_BLOCK,
        KIND_LINE,
        KIND_DIR,
        KIND_NL,
        KIND_OTHER
    } kind_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        kind_t      kind;
        logic       last;
    } beat_t;

    typedef struct packed {
        mode_t                 mode;
        logic                  prev_star;
        logic [LimitWidth-1:0] count;
    } scan_state_t;

    // One result slot together with the state it leaves behind.
    typedef struct packed {
        logic        v;
        beat_t       b;
        scan_state_t st;
    } step_t;

    localparam scan_state_t IDLE_ST = '{mode: MODE_IDLE, prev_star: 1'b0, count: '0};

endpackage

[rtl/core/csts_scan.sv]
// ----------------------------------------------------------------------------
// csts_scan
// Next-state and result logic of the tokenizer: from the scan state, one
// input character and the length cap, form up to two result beats.
// ----------------------------------------------------------------------------
module csts_scan
    import csts_pkg::*;
(
    input  scan_state_t            st,
    input  logic [7:0]             ch,
    input  logic                   flush,
    input  logic [LimitWidth-1:0]  limit,
    output scan_state_t            st_next,
    output logic                   res0_valid,
    output beat_t                  res0,
    output logic                   res1_valid,
    output beat_t                  res1
);

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic kind_t mode_kind(input mode_t m);
        kind_t k;
        case (m)
            MODE_BLOCK: k = KIND_BLOCK;
            MODE_LINE:  k = KIND_LINE;
            MODE_DIR:   k = KIND_DIR;
            MODE_STR:   k = KIND_STR;
            MODE_NUM:   k = KIND_NUM;
            MODE_IDENT: k = KIND_IDENT;
            default:    k = KIND_OTHER;
        endcase
        return k;
    endfunction

    function automatic step_t add_char(input scan_state_t s, input logic [7:0] c,
                                       input kind_t k, input mode_t m,
                                       input logic closes, input logic star,
                                       input logic [LimitWidth-1:0] lim);
        step_t                 r;
        logic [LimitWidth-1:0] cnt;
        logic                  fin;
        cnt  = s.count + 1'b1;
        fin  = closes || (cnt >= lim);
        r.v  = 1'b1;
        r.b  = '{out_char: c, has_char: 1'b1, kind: k, last: fin};
        r.st = fin ? IDLE_ST : scan_state_t'{mode: m, prev_star: star, count: cnt};
        return r;
    endfunction

    function automatic step_t idle_scan(input logic [7:0] c,
                                        input logic [LimitWidth-1:0] lim);
        step_t r;
        r.v  = 1'b0;
        r.b  = '0;
        r.st = IDLE_ST;
        if (is_blank(c)) begin
            r.v = 1'b0;
        end
        else if (c == CH_NL) begin
            r.v = 1'b1;
            r.b = '{out_char: c, has_char: 1'b1, kind: KIND_NL, last: 1'b1};
        end
        else if (c == CH_SLASH) begin
            if (lim <= 10'd1) begin
                r.v = 1'b1;
                r.b = '{out_char: c, has_char: 1'b1, kind: KIND_OTHER, last: 1'b1};
            end
            else begin
                r.st = '{mode: MODE_SLASH, prev_star: 1'b0, count: 10'd1};
            end
        end
        else if (c == CH_HASH) begin
            r = add_char(IDLE_ST, c, KIND_DIR, MODE_DIR, 1'b0, 1'b0, lim);
        end
        else if (c == CH_QUOTE) begin
            r = add_char(IDLE_ST, c, KIND_STR, MODE_STR, 1'b0, 1'b0, lim);
        end
        else if (is_digit(c)) begin
            r = add_char(IDLE_ST, c, KIND_NUM, MODE_NUM, 1'b0, 1'b0, lim);
        end
        else if (is_alpha(c) || (c == CH_USCORE)) begin
            r = add_char(IDLE_ST, c, KIND_IDENT, MODE_IDENT, 1'b0, 1'b0, lim);
        end
        else begin
            r.v = 1'b1;
            r.b = '{out_char: c, has_char: 1'b1, kind: KIND_OTHER, last: 1'b1};
        end
        return r;
    endfunction

    logic [LimitWidth-1:0] lim;
    step_t                 a;
    logic                  accept;
    beat_t                 slash_beat;

    assign lim = (limit == '0) ? 10'd1 : limit;

    always_comb
    begin
        st_next    = st;
        res0_valid = 1'b0;
        res0       = '0;
        res1_valid = 1'b0;
        res1       = '0;
        a          = '0;
        accept     = 1'b0;
        slash_beat = '{out_char: CH_SLASH, has_char: 1'b1, kind: KIND_OTHER, last: 1'b1};
        if (flush) begin
            st_next = IDLE_ST;
            if (st.mode == MODE_SLASH) begin
                res0_valid = 1'b1;
                res0       = slash_beat;
            end
            else if (st.mode != MODE_IDLE) begin
                res0_valid = 1'b1;
                res0       = '{out_char: 8'h00, has_char: 1'b0,
                               kind: mode_kind(st.mode), last: 1'b1};
            end
        end
        else begin
            case (st.mode)
                MODE_SLASH:
                begin
                    res0_valid = 1'b1;
                    if (ch == CH_STAR) begin
                        res0 = '{out_char: CH_SLASH, has_char: 1'b1,
                                 kind: KIND_BLOCK, last: 1'b0};
                        a    = add_char(st, ch, KIND_BLOCK, MODE_BLOCK, 1'b0, 1'b0, lim);
                    end
                    else if (ch == CH_SLASH) begin
                        res0 = '{out_char: CH_SLASH, has_char: 1'b1,
                                 kind: KIND_LINE, last: 1'b0};
                        a    = add_char(st, ch, KIND_LINE, MODE_LINE, 1'b0, 1'b0, lim);
                    end
                    else begin
                        res0 = slash_beat;
                        a    = idle_scan(ch, lim);
                    end
                    res1_valid = a.v;
                    res1       = a.b;
                    st_next    = a.st;
                end
                MODE_BLOCK:
                begin
                    a = add_char(st, ch, KIND_BLOCK, MODE_BLOCK,
                                 st.prev_star && (ch == CH_SLASH), ch == CH_STAR, lim);
                    res0_valid = a.v;
                    res0       = a.b;
                    st_next    = a.st;
                end
                MODE_LINE:
                begin
                    a = add_char(st, ch, KIND_LINE, MODE_LINE, ch == CH_NL, 1'b0, lim);
                    res0_valid = a.v;
                    res0       = a.b;
                    st_next    = a.st;
                end
                MODE_STR:
                begin
                    a = add_char(st, ch, KIND_STR, MODE_STR,
                                 (ch == CH_QUOTE) || (ch == CH_NL), 1'b0, lim);
                    res0_valid = a.v;
                    res0       = a.b;
                    st_next    = a.st;
                end
                MODE_DIR, MODE_NUM, MODE_IDENT:
                begin
                    case (st.mode)
                        MODE_DIR:   accept = is_digit(ch) || is_alpha(ch);
                        MODE_NUM:   accept = is_digit(ch);
                        default:    accept = is_digit(ch) || is_alpha(ch) ||
                                             (ch == CH_USCORE);
                    endcase
                    if (accept) begin
                        a = add_char(st, ch, mode_kind(st.mode), st.mode, 1'b0, 1'b0, lim);
                        res0_valid = a.v;
                        res0       = a.b;
                        st_next    = a.st;
                    end
                    else begin
                        // end the run with a bare marker, then rescan ch
                        res0_valid = 1'b1;
                        res0       = '{out_char: 8'h00, has_char: 1'b0,
                                       kind: mode_kind(st.mode), last: 1'b1};
                        a          = idle_scan(ch, lim);
                        res1_valid = a.v;
                        res1       = a.b;
                        st_next    = a.st;
                    end
                end
                default:
                begin
                    a = idle_scan(ch, lim);
                    res0_valid = a.v;
                    res0       = a.b;
                    st_next    = a.st;
                end
            endcase
        end
    end

endmodule

[rtl/core/csts_outq.sv]
// ----------------------------------------------------------------------------
// csts_outq
// Four-entry result queue: takes up to two beats per cycle, hands out one.
// Reports room while at least two entries are free.
// ----------------------------------------------------------------------------
module csts_outq
    import csts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push0,
    input  beat_t push0_beat,
    input  logic  push1,
    input  beat_t push1_beat,
    output logic  room,
    output logic  out_valid,
    input  logic  out_ready,
    output beat_t out_beat
);

    beat_t      q_mem [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 3'd0);
    assign out_beat  = q_mem[rd_ptr_reg];
    assign room      = (count_reg <= 3'd2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + {1'b0, push0} + {1'b0, push1};
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {2'b0, push0} + {2'b0, push1} - {2'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0) begin
            q_mem[wr_ptr_reg] <= push0_beat;
        end
        if (push1) begin
            q_mem[wr_ptr_reg + 2'd1] <= push1_beat;
        end
    end

endmodule

[rtl/core/c_source_token_splitter.sv]
// ----------------------------------------------------------------------------
// c_source_token_splitter
// Splits a stream of C source bytes into tagged token beats.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one source byte ch per beat, or a flush
// beat that closes any open token. Output channel (out_valid/out_ready): one
// token character per beat with its kind, has_char = 0 for a bare end
// marker, last on the final beat of a token. cfg_valid/cfg_ready writes the
// 10-bit token length cap (cfg_ready is always high); write it only while
// the block is idle.
// Path: a byte accepted into the input register is scanned from there and
// its beats are written into the result queue, which drives the output.
// Throughput: one byte per cycle while results leave one per
// cycle; a byte that yields two beats (held slash or end of a run) adds an
// extra output beat, which the four-entry result queue absorbs.
// Stall: in_ready drops while a byte is held and the result queue has fewer
// than two free entries; the input register then holds its byte.
// Reset: scanner idle, queue empty, cap back to 100.
// ----------------------------------------------------------------------------
module c_source_token_splitter
    import csts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            ch,
    input  logic                  flush,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_char,
    output logic                  has_char,
    output logic [2:0]            kind,
    output logic                  last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LimitWidth-1:0] cfg_data
);

    logic                  in_valid_reg;
    logic [7:0]            in_ch_reg;
    logic                  in_flush_reg;
    scan_state_t           state_reg;
    scan_state_t           state_next;
    logic [LimitWidth-1:0] limit_reg;
    logic                  room;
    logic                  proc_fire;
    logic                  res0_valid;
    logic                  res1_valid;
    beat_t                 res0;
    beat_t                 res1;
    beat_t                 out_beat;

    assign cfg_ready = 1'b1;
    assign proc_fire = in_valid_reg && room;
    assign in_ready  = !in_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            state_reg    <= IDLE_ST;
            limit_reg    <= LIMIT_RESET;
        end
        else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (proc_fire) begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            in_ch_reg    <= ch;
            in_flush_reg <= flush;
        end
    end

    csts_scan u_scan (
        .st         (state_reg),
        .ch         (in_ch_reg),
        .flush      (in_flush_reg),
        .limit      (limit_reg),
        .st_next    (state_next),
        .res0_valid (res0_valid),
        .res0       (res0),
        .res1_valid (res1_valid),
        .res1       (res1)
    );

    csts_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0      (proc_fire && res0_valid),
        .push0_beat (res0),
        .push1      (proc_fire && res1_valid),
        .push1_beat (res1),
        .room       (room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_beat   (out_beat)
    );

    assign out_char = out_beat.out_char;
    assign has_char = out_beat.has_char;
    assign kind     = out_beat.kind;
    assign last     = out_beat.last;

endmodule

[rtl/core/csts_checker.sv]
// ----------------------------------------------------------------------------
// csts_checker
// Port-level checks on the token splitter output channel.
// ----------------------------------------------------------------------------
module csts_checker
    import csts_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       has_char,
    input logic [2:0] kind,
    input logic       last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_char) && $stable(has_char) &&
                                    $stable(kind) && $stable(last))
        else $error("output payload changed while stalled");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_char |-> last && (out_char == 8'h00))
        else $error("bare end marker without last or with a character");

    a_newline: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_NL) |-> has_char && last && (out_char == CH_NL))
        else $error("newline token malformed");

endmodule

bind c_source_token_splitter csts_checker u_csts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .has_char  (has_char),
    .kind      (kind),
    .last      (last)
);

[test/c_source_token_splitter_checker.sv]
// ----------------------------------------------------------------------------
// c_source_token_splitter_checker
// Watches the byte, token and cap channels of the token splitter, keeps its
// own scanner state to work out the token beats each accepted byte must
// produce, and compares every delivered beat field by field, in order.
// ----------------------------------------------------------------------------
module c_source_token_splitter_checker
    import csts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [7:0]            ch,
    input  logic                  flush,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [7:0]            out_char,
    input  logic                  has_char,
    input  logic [2:0]            kind,
    input  logic                  last,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [LimitWidth-1:0] cfg_data,
    output int                    mismatches,
    output int                    beats_due
);
    timeunit 1ns;
    timeprecision 1ps;

    mode_t                 scan_mode;
    logic                  star_seen;
    logic [LimitWidth-1:0] tok_len;
    logic [LimitWidth-1:0] cap;
    beat_t                 token_beats[$];

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    function automatic logic [LimitWidth-1:0] cap_eff();
        return (cap == '0) ? LimitWidth'(1) : cap;
    endfunction

    function automatic kind_t kind_of(mode_t m);
        case (m)
            MODE_BLOCK: return KIND_BLOCK;
            MODE_LINE:  return KIND_LINE;
            MODE_DIR:   return KIND_DIR;
            MODE_STR:   return KIND_STR;
            MODE_NUM:   return KIND_NUM;
            MODE_IDENT: return KIND_IDENT;
            default:    return KIND_OTHER;
        endcase
    endfunction

    task automatic push_beat(logic [7:0] c, logic has, kind_t k, logic lst);
        beat_t b;
        b.out_char = has ? c : 8'h00;
        b.has_char = has;
        b.kind     = k;
        b.last     = lst;
        token_beats.push_back(b);
    endtask

    task automatic go_idle();
        scan_mode = MODE_IDLE;
        tok_len   = '0;
        star_seen = 1'b0;
    endtask

    // Append to the open token; close it on the terminator or at the cap.
    task automatic append(logic [7:0] c, kind_t k, logic closes);
        logic lst;
        tok_len = tok_len + 1'b1;
        lst     = closes || tok_len >= cap_eff();
        push_beat(c, 1'b1, k, lst);
        if (lst)
            go_idle();
    endtask

    task automatic start_token(logic [7:0] c);
        if (is_blank(c))
            ;
        else if (c == CH_NL)
            push_beat(c, 1'b1, KIND_NL, 1'b1);
        else if (c == CH_SLASH)
        begin
            if (cap_eff() <= 1)
                push_beat(c, 1'b1, KIND_OTHER, 1'b1);
            else
            begin
                scan_mode = MODE_SLASH;
                tok_len   = LimitWidth'(1);
            end
        end
        else if (c == CH_HASH)
        begin
            scan_mode = MODE_DIR;
            tok_len   = '0;
            append(c, KIND_DIR, 1'b0);
        end
        else if (c == CH_QUOTE)
        begin
            scan_mode = MODE_STR;
            tok_len   = '0;
            append(c, KIND_STR, 1'b0);
        end
        else if (is_digit(c))
        begin
            scan_mode = MODE_NUM;
            tok_len   = '0;
            append(c, KIND_NUM, 1'b0);
        end
        else if (is_alpha(c) || c == CH_USCORE)
        begin
            scan_mode = MODE_IDENT;
            tok_len   = '0;
            append(c, KIND_IDENT, 1'b0);
        end
        else
            push_beat(c, 1'b1, KIND_OTHER, 1'b1);
    endtask

    // Extend a run token, or end it with a bare marker and rescan the byte.
    task automatic extend_run(logic [7:0] c, logic accept, kind_t k);
        if (accept)
            append(c, k, 1'b0);
        else
        begin
            push_beat(8'h00, 1'b0, k, 1'b1);
            go_idle();
            start_token(c);
        end
    endtask

    task automatic scan_byte(logic [7:0] c, logic f);
        logic closes;
        if (f)
        begin
            if (scan_mode == MODE_SLASH)
                push_beat(CH_SLASH, 1'b1, KIND_OTHER, 1'b1);
            else if (scan_mode != MODE_IDLE)
                push_beat(8'h00, 1'b0, kind_of(scan_mode), 1'b1);
            go_idle();
        end
        else
        begin
            case (scan_mode)
                MODE_SLASH:
                    if (c == CH_STAR)
                    begin
                        scan_mode = MODE_BLOCK;
                        star_seen = 1'b0;
                        push_beat(CH_SLASH, 1'b1, KIND_BLOCK, 1'b0);
                        append(c, KIND_BLOCK, 1'b0);
                    end
                    else if (c == CH_SLASH)
                    begin
                        scan_mode = MODE_LINE;
                        push_beat(CH_SLASH, 1'b1, KIND_LINE, 1'b0);
                        append(c, KIND_LINE, 1'b0);
                    end
                    else
                    begin
                        push_beat(CH_SLASH, 1'b1, KIND_OTHER, 1'b1);
                        go_idle();
                        start_token(c);
                    end
                MODE_BLOCK:
                begin
                    closes    = star_seen && c == CH_SLASH;
                    star_seen = (c == CH_STAR);
                    append(c, KIND_BLOCK, closes);
                end
                MODE_LINE:  append(c, KIND_LINE, c == CH_NL);
                MODE_STR:   append(c, KIND_STR, c == CH_QUOTE || c == CH_NL);
                MODE_DIR:   extend_run(c, is_digit(c) || is_alpha(c), KIND_DIR);
                MODE_NUM:   extend_run(c, is_digit(c), KIND_NUM);
                MODE_IDENT: extend_run(c, is_digit(c) || is_alpha(c) || c == CH_USCORE,
                                       KIND_IDENT);
                default:
                begin
                    go_idle();
                    start_token(c);
                end
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        beat_t want;
        if (!rst_n)
        begin
            cap = LIMIT_RESET;
            go_idle();
            token_beats.delete();
            mismatches = 0;
            beats_due  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (token_beats.size() == 0)
                begin
                    $error("unexpected beat: out_char %0h has_char %0b kind %0d last %0b",
                           out_char, has_char, kind, last);
                    mismatches++;
                end
                else
                begin
                    want = token_beats.pop_front();
                    if (out_char !== want.out_char)
                    begin
                        $error("out_char: expected %0h, got %0h", want.out_char, out_char);
                        mismatches++;
                    end
                    if (has_char !== want.has_char)
                    begin
                        $error("has_char: expected %0b, got %0b", want.has_char, has_char);
                        mismatches++;
                    end
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        mismatches++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, last);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                cap = cfg_data;
            if (in_valid && in_ready)
                scan_byte(ch, flush);
            beats_due = token_beats.size();
        end
    end

endmodule

[test/c_source_token_splitter_tb.sv]
// ----------------------------------------------------------------------------
// c_source_token_splitter_tb
// Feeds the token splitter directed C fragments and then a long random mix
// of well-formed tokens, noise bytes and flushes under several length caps
// and idle patterns; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module c_source_token_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csts_pkg::*;

    localparam int SegItems   = 100;
    localparam int CycleLimit = 400000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [7:0]            ch        = 8'h00;
    logic                  flush     = 1'b0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [LimitWidth-1:0] cfg_data  = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic [7:0]            out_char;
    logic                  has_char;
    logic [2:0]            kind;
    logic                  last;
    logic                  cfg_ready;

    int mismatches;
    int beats_due;
    int send_gap   = 0;
    int stall_pct  = 0;
    int cycles     = 0;
    int seg_items  = 0;

    logic [LimitWidth-1:0] caps[9] = '{10'd5, 10'd1023, 10'd2, 10'd12, 10'd1, 10'd0,
                                       10'd3, 10'd100, 10'd40};

    c_source_token_splitter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .flush     (flush),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .has_char  (has_char),
        .kind      (kind),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    c_source_token_splitter_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .flush      (flush),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .has_char   (has_char),
        .kind       (kind),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .beats_due  (beats_due)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] letter();
        return ($urandom_range(0, 1) == 0) ? 8'("a" + $urandom_range(0, 25))
                                            : 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] alnum();
        return ($urandom_range(0, 2) == 0) ? digit() : letter();
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    task automatic send_beat(logic [7:0] c, logic f);
        while ($urandom_range(0, 99) < send_gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        flush    <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_text(string s);
        foreach (s[i])
            send_beat(s[i], 1'b0);
    endtask

    // Hold the sender until every pending beat has left the block.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (beats_due != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_cap(logic [LimitWidth-1:0] v);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_fragment();
        logic [7:0] frag[$];
        int         sel;
        int         len;
        logic       counted;
        sel     = $urandom_range(0, 99);
        len     = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
        counted = 1'b1;
        if (sel < 18)
        begin
            frag.push_back(($urandom_range(0, 3) == 0) ? CH_USCORE : letter());
            repeat (len) frag.push_back(($urandom_range(0, 5) == 0) ? CH_USCORE : alnum());
        end
        else if (sel < 30)
            repeat (len + 1) frag.push_back(digit());
        else if (sel < 40)
        begin
            frag.push_back(CH_QUOTE);
            repeat (len) frag.push_back(printable());
            frag.push_back(($urandom_range(0, 3) == 0) ? CH_NL : CH_QUOTE);
        end
        else if (sel < 50)
        begin
            frag.push_back(CH_SLASH);
            frag.push_back(CH_STAR);
            repeat (len)
            begin
                case ($urandom_range(0, 4))
                    0:       frag.push_back(CH_STAR);
                    1:       frag.push_back(CH_SLASH);
                    2:       frag.push_back(CH_NL);
                    default: frag.push_back(printable());
                endcase
            end
            frag.push_back(CH_STAR);
            frag.push_back(CH_SLASH);
        end
        else if (sel < 58)
        begin
            frag.push_back(CH_SLASH);
            frag.push_back(CH_SLASH);
            repeat (len) frag.push_back(printable());
            frag.push_back(CH_NL);
        end
        else if (sel < 66)
        begin
            frag.push_back(CH_HASH);
            repeat (len) frag.push_back(alnum());
        end
        else if (sel < 76)
        begin
            counted = 1'b0;
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 5))
                    0:       frag.push_back(CH_TAB);
                    1:       frag.push_back(CH_VT);
                    2:       frag.push_back(CH_FF);
                    3:       frag.push_back(CH_CR);
                    4:       frag.push_back(CH_NL);
                    default: frag.push_back(CH_SPACE);
                endcase
            end
        end
        else if (sel < 86)
        begin
            case ($urandom_range(0, 5))
                0, 1:    frag.push_back(CH_SLASH);
                2:       frag.push_back(CH_STAR);
                3:       frag.push_back("+");
                4:       frag.push_back("(");
                default: frag.push_back(";");
            endcase
        end
        else if (sel < 96)
            repeat (len + 1) frag.push_back(8'($urandom_range(0, 255)));
        else
        begin
            send_beat(8'($urandom_range(0, 255)), 1'b1);
            seg_items++;
        end
        foreach (frag[i])
            send_beat(frag[i], 1'b0);
        if (counted)
            seg_items += frag.size();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_text("x_9+");
        send_text("7 ");
        send_text("\"\n");
        send_text("/**/");
        send_text("//\n");
        send_text("#d(");
        send_text("/a");
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b1);
        send_beat(CH_SLASH, 1'b0);
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        set_cap(10'd1);
        send_text("/ab");
        set_cap(10'd0);
        send_text("\"q");

        for (int phase = 0; phase < 3; phase++)
        begin
            send_gap   = (phase == 0) ? 23 : (phase == 1) ? 72 : 0;
            stall_pct <= (phase == 0) ? 72 : (phase == 1) ? 23 : 0;
            for (int seg = 0; seg < 3; seg++)
            begin
                set_cap(caps[phase * 3 + seg]);
                seg_items = 0;
                while (seg_items < SegItems / 2)
                    send_fragment();
                drain();
                while (seg_items < SegItems)
                    send_fragment();
            end
        end

        drain();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
